@@ sv/dat_name_hash_extractor_defines.svh @@
// Assertion macros for the catalog name/hash extractor
`ifndef DAT_NAME_HASH_EXTRACTOR_DEFINES_SVH
`define DAT_NAME_HASH_EXTRACTOR_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define DNH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define DNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dnh_pkg.sv @@
// Shared types and constants of the catalog name/hash extractor
package dnh_pkg;

    localparam int unsigned HASH_MAX_LEN_DEF = 254;
    localparam int unsigned KEYWORD_LEN      = 4;
    localparam logic [7:0]  NAME_MAX_RST     = 8'd255;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [2:0] {
        KIND_NAME_BYTE  = 3'd0,
        KIND_NAME_END   = 3'd1,
        KIND_HASH_BYTE  = 3'd2,
        KIND_HASH_FOUND = 3'd3,
        KIND_NOT_FOUND  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [1:0] count;
        logic       done;
        t_item      item0;
        t_item      item1;
    } t_push;

endpackage

@@ sv/dnh_if.sv @@
// Valid/ready channel interfaces for input bytes and result items
interface dnh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface dnh_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_kind, output out_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_last,
                    output ready);
endinterface

@@ sv/dnh_core.sv @@
// Tokenizer and keyword search state with result item generation
module dnh_core #(
    parameter int unsigned HashMaxLen = dnh_pkg::HASH_MAX_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [7:0]    i_cfg_wr_data,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    input  logic          i_eoi,
    output dnh_pkg::t_push o_push
);

    typedef enum logic [2:0] {
        PH_GAME   = 3'd0,
        PH_NAMEKW = 3'd1,
        PH_NAME   = 3'd2,
        PH_SHA    = 3'd3,
        PH_HASH   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    localparam logic [8:0] HASH_LIMIT = 9'(HashMaxLen);
    localparam logic [8:0] KW_LIMIT   = 9'(dnh_pkg::KEYWORD_LEN);

    function automatic logic [7:0] kw_char(input t_phase ph, input logic [1:0] idx);
        logic [31:0] word;
        word = 32'h0;
        unique case (ph)
            PH_GAME:   word = {"g", "a", "m", "e"};
            PH_NAMEKW: word = {"n", "a", "m", "e"};
            default:   word = {"s", "h", "a", "1"};
        endcase
        return word[8 * (3 - idx) +: 8];
    endfunction

    t_phase     r_phase, n_phase;
    logic       r_quote, n_quote;
    logic [7:0] r_tlen,  n_tlen;
    logic       r_match, n_match;
    logic [7:0] r_name_max;

    logic       ws;
    logic [8:0] tlen_inc;
    logic [8:0] name_limit;
    logic       miss;
    dnh_pkg::t_push push;

    assign ws = (i_byte == dnh_pkg::CH_SPACE) || (i_byte == dnh_pkg::CH_TAB) ||
                (i_byte == dnh_pkg::CH_CR)    || (i_byte == dnh_pkg::CH_LF);
    assign tlen_inc   = {1'b0, r_tlen} + 9'd1;
    assign name_limit = (r_name_max == 8'd0) ? 9'd1 : {1'b0, r_name_max};
    assign miss = (tlen_inc > KW_LIMIT) || (i_byte != kw_char(r_phase, r_tlen[1:0]));

    always_comb begin
        n_phase = r_phase;
        n_quote = r_quote;
        n_tlen  = r_tlen;
        n_match = r_match;
        push    = '0;
        if (i_take && r_phase != PH_DONE) begin
            if (i_eoi) begin
                push.count      = 2'd1;
                push.item0.kind = dnh_pkg::KIND_NOT_FOUND;
                n_phase = PH_DONE;
                n_quote = 1'b0;
                n_tlen  = 8'd0;
                n_match = 1'b1;
            end else if (ws && r_tlen == 8'd0) begin
                n_phase = r_phase;
            end else if (ws && !r_quote) begin
                if (r_phase == PH_NAME) begin
                    push.count      = 2'd1;
                    push.item0.kind = dnh_pkg::KIND_NAME_END;
                    n_phase = PH_SHA;
                end else if (r_phase == PH_HASH) begin
                    push.count      = 2'd1;
                    push.item0.kind = dnh_pkg::KIND_HASH_FOUND;
                    n_phase = PH_DONE;
                end
                n_quote = 1'b0;
                n_tlen  = 8'd0;
                n_match = 1'b1;
            end else begin
                n_quote = r_quote ^ (i_byte == dnh_pkg::CH_QUOTE);
                n_tlen  = tlen_inc[7:0];
                if (r_phase == PH_NAME || r_phase == PH_HASH) begin
                    push.count      = 2'd1;
                    push.item0.kind = (r_phase == PH_NAME) ? dnh_pkg::KIND_NAME_BYTE
                                                           : dnh_pkg::KIND_HASH_BYTE;
                    push.item0.data = i_byte;
                    if (r_phase == PH_NAME && tlen_inc >= name_limit) begin
                        push.count      = 2'd2;
                        push.item1.kind = dnh_pkg::KIND_NAME_END;
                        n_phase = PH_SHA;
                        n_quote = 1'b0;
                        n_tlen  = 8'd0;
                        n_match = 1'b1;
                    end else if (r_phase == PH_HASH && tlen_inc >= HASH_LIMIT) begin
                        push.count      = 2'd2;
                        push.item1.kind = dnh_pkg::KIND_HASH_FOUND;
                        n_phase = PH_DONE;
                        n_quote = 1'b0;
                        n_tlen  = 8'd0;
                        n_match = 1'b1;
                    end
                end else begin
                    n_match = r_match && !miss;
                    if (tlen_inc >= KW_LIMIT) begin
                        if (r_match && !miss) begin
                            unique case (r_phase)
                                PH_GAME:   n_phase = PH_NAMEKW;
                                PH_NAMEKW: n_phase = PH_NAME;
                                default:   n_phase = PH_HASH;
                            endcase
                        end
                        n_quote = 1'b0;
                        n_tlen  = 8'd0;
                        n_match = 1'b1;
                    end
                end
            end
        end
        push.item0.last = (push.count == 2'd1);
        push.item1.last = (push.count == 2'd2);
        push.done       = (r_phase == PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_GAME;
            r_quote    <= 1'b0;
            r_tlen     <= 8'd0;
            r_match    <= 1'b1;
            r_name_max <= dnh_pkg::NAME_MAX_RST;
        end else begin
            r_phase <= n_phase;
            r_quote <= n_quote;
            r_tlen  <= n_tlen;
            r_match <= n_match;
            if (i_cfg_wr_en) begin
                r_name_max <= i_cfg_wr_data;
            end
        end
    end

    assign o_push = push;

endmodule

@@ sv/dat_name_hash_extractor.sv @@
// Top level of the catalog name/hash extractor with result queue
//
// channel  dir  handshake     payload
// i_in     in   valid/ready   in_byte[7:0], end_of_input
// o_out    out  valid/ready   out_kind[2:0], out_byte[7:0], out_last
// i_cfg    in   wr_en         wr_data[7:0] (name_max_len)
//
// One input byte per cycle is taken while input ready is high; its 0 to 2 result
// items enter a four-entry result queue in the same cycle and leave one per cycle
// while the output is ready. Input ready is high while the queue has room for two
// items, so a byte that yields two items takes two output transfers to drain.
// Reset is synchronous and active low; the queue empties and the search restarts.
`include "dat_name_hash_extractor_defines.svh"

module dat_name_hash_extractor #(
    parameter int unsigned HashMaxLen = dnh_pkg::HASH_MAX_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [7:0]      i_cfg_wr_data,
    dnh_in_if.sink          i_in,
    dnh_out_if.source       o_out
);

    localparam int unsigned AW = dnh_pkg::QUEUE_AW;
    localparam int unsigned CW = dnh_pkg::QUEUE_CW;

    dnh_pkg::t_item r_queue [dnh_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    logic           take;
    logic           pop;
    dnh_pkg::t_push push;
    dnh_pkg::t_item head;

    assign i_in.ready = (r_count <= CW'(dnh_pkg::QUEUE_DEPTH - 2));
    assign take       = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    dnh_core #(
        .HashMaxLen(HashMaxLen)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_take       (take),
        .i_byte       (i_in.in_byte),
        .i_eoi        (i_in.end_of_input),
        .o_push       (push)
    );

    assign n_wr_ptr = r_wr_ptr + AW'(push.count);
    assign n_rd_ptr = r_rd_ptr + AW'(pop);
    assign n_count  = r_count + CW'(push.count) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (push.count != 2'd0) begin
            r_queue[r_wr_ptr] <= push.item0;
        end
        if (push.count == 2'd2) begin
            r_queue[r_wr_ptr + AW'(1)] <= push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign head           = r_queue[r_rd_ptr];
    assign o_out.valid    = (r_count != '0);
    assign o_out.out_kind = head.kind;
    assign o_out.out_byte = head.data;
    assign o_out.out_last = head.last;

    `DNH_ASSERT_NOW(a_queue_bound, 1'b1, r_count <= CW'(dnh_pkg::QUEUE_DEPTH),
        "result queue over capacity")
    `DNH_ASSERT_NOW(a_push_room, take, r_count <= CW'(dnh_pkg::QUEUE_DEPTH - 2),
        "input transfer without queue room")
    `DNH_ASSERT_NOW(a_done_silent, push.done, push.count == 2'd0,
        "result pushed after search finished")
    `DNH_ASSERT_NEXT(a_two_last, push.count == 2'd2,
        $past(push.item1.last) && !$past(push.item0.last),
        "last flag misplaced on two-item transfer")

endmodule

@@ tb/tb_dat_name_hash_extractor.sv @@
// Testbench for dat_name_hash_extractor: predicted name/hash items checked under random stalls
module tb_dat_name_hash_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SEEK_GAME,
        SEEK_NAME,
        GRAB_NAME,
        SEEK_SHA1,
        GRAB_HASH,
        SEARCH_DONE
    } t_search_phase;

    localparam int unsigned LONG_HOLD     = 60;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES  = 16;

    class t_catalog_scoreboard;
        t_search_phase  phase;
        bit             quote_open;
        int unsigned    token_len;
        bit             chunk_ok;
        logic [7:0]     name_limit;
        dnh_pkg::t_item pending_items[$];
        int unsigned    mismatches;

        function new();
            phase      = SEEK_GAME;
            name_limit = dnh_pkg::NAME_MAX_RST;
            mismatches = 0;
            clear_token();
        endfunction

        function void clear_token();
            token_len  = 0;
            quote_open = 1'b0;
            chunk_ok   = 1'b1;
        endfunction

        function void set_name_limit(logic [7:0] v);
            name_limit = v;
        endfunction

        function logic [7:0] keyword_byte(t_search_phase ph, int unsigned idx);
            string kw;
            case (ph)
                SEEK_GAME: kw = "game";
                SEEK_NAME: kw = "name";
                default:   kw = "sha1";
            endcase
            return kw[idx];
        endfunction

        // predict the result items of one accepted transfer
        function void note_transfer(logic [7:0] b, logic eoi);
            dnh_pkg::t_item fresh[2];
            int unsigned    n;
            int unsigned    lim;
            bit             is_space;
            n = 0;
            is_space = (b == dnh_pkg::CH_SPACE) || (b == dnh_pkg::CH_TAB) ||
                       (b == dnh_pkg::CH_CR)    || (b == dnh_pkg::CH_LF);
            if (phase == SEARCH_DONE) begin
                return;
            end
            if (eoi) begin
                fresh[n] = '{kind: dnh_pkg::KIND_NOT_FOUND, data: 8'd0, last: 1'b0};
                n++;
                phase = SEARCH_DONE;
                clear_token();
            end else if (is_space && token_len == 0) begin
                return;
            end else if (is_space && !quote_open) begin
                if (phase == GRAB_NAME) begin
                    fresh[n] = '{kind: dnh_pkg::KIND_NAME_END, data: 8'd0, last: 1'b0};
                    n++;
                    phase = SEEK_SHA1;
                end else if (phase == GRAB_HASH) begin
                    fresh[n] = '{kind: dnh_pkg::KIND_HASH_FOUND, data: 8'd0, last: 1'b0};
                    n++;
                    phase = SEARCH_DONE;
                end
                clear_token();
            end else begin
                if (b == dnh_pkg::CH_QUOTE) begin
                    quote_open = !quote_open;
                end
                case (phase)
                    GRAB_NAME: begin
                        lim = (name_limit == 8'd0) ? 1 : int'(name_limit);
                        fresh[n] = '{kind: dnh_pkg::KIND_NAME_BYTE, data: b, last: 1'b0};
                        n++;
                        token_len++;
                        if (token_len >= lim) begin
                            fresh[n] = '{kind: dnh_pkg::KIND_NAME_END, data: 8'd0,
                                         last: 1'b0};
                            n++;
                            phase = SEEK_SHA1;
                            clear_token();
                        end
                    end
                    GRAB_HASH: begin
                        fresh[n] = '{kind: dnh_pkg::KIND_HASH_BYTE, data: b, last: 1'b0};
                        n++;
                        token_len++;
                        if (token_len >= dnh_pkg::HASH_MAX_LEN_DEF) begin
                            fresh[n] = '{kind: dnh_pkg::KIND_HASH_FOUND, data: 8'd0,
                                         last: 1'b0};
                            n++;
                            phase = SEARCH_DONE;
                            clear_token();
                        end
                    end
                    default: begin
                        if (token_len >= dnh_pkg::KEYWORD_LEN ||
                            b != keyword_byte(phase, token_len)) begin
                            chunk_ok = 1'b0;
                        end
                        token_len++;
                        if (token_len >= dnh_pkg::KEYWORD_LEN) begin
                            if (chunk_ok) begin
                                phase = t_search_phase'(phase + 3'd1);
                            end
                            clear_token();
                        end
                    end
                endcase
            end
            if (n > 0) begin
                fresh[n - 1].last = 1'b1;
            end
            for (int unsigned k = 0; k < n; k++) begin
                pending_items.push_back(fresh[k]);
            end
        endfunction

        function void check_item(logic [2:0] kind, logic [7:0] data, logic last);
            dnh_pkg::t_item exp_item;
            if (pending_items.size() == 0) begin
                $error("result with nothing pending: out_kind %0d out_byte %02h", kind, data);
                mismatches++;
                return;
            end
            exp_item = pending_items.pop_front();
            if (kind !== exp_item.kind) begin
                $error("out_kind expected %0d actual %0d", exp_item.kind, kind);
                mismatches++;
            end
            if (data !== exp_item.data) begin
                $error("out_byte expected %02h actual %02h", exp_item.data, data);
                mismatches++;
            end
            if (last !== exp_item.last) begin
                $error("out_last expected %0b actual %0b", exp_item.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    bit          calm;
    bit          hold_armed;
    bit          hold_done;
    int unsigned bytes_sent;

    t_catalog_scoreboard sb = new();

    dnh_in_if  in_ch();
    dnh_out_if out_ch();

    dat_name_hash_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == dnh_pkg::CH_SPACE || b == dnh_pkg::CH_TAB ||
                   b == dnh_pkg::CH_CR || b == dnh_pkg::CH_LF ||
                   b == dnh_pkg::CH_QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0:       return dnh_pkg::CH_SPACE;
            1:       return dnh_pkg::CH_TAB;
            2:       return dnh_pkg::CH_CR;
            default: return dnh_pkg::CH_LF;
        endcase
    endfunction

    function automatic string pick_other(string kw);
        string s;
        do begin
            case ($urandom_range(0, 2))
                0:       s = "game";
                1:       s = "name";
                default: s = "sha1";
            endcase
        end while (s == kw);
        return s;
    endfunction

    task automatic send_byte(logic [7:0] b, logic eoi);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.in_byte      = b;
        in_ch.end_of_input = eoi;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        bytes_sent++;
        sb.note_transfer(b, eoi);
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic send_text(string s);
        for (int unsigned k = 0; k < s.len(); k++) begin
            send_byte(s[k], 1'b0);
        end
    endtask

    task automatic send_spaces();
        int unsigned n;
        n = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n; k++) begin
            send_byte(pick_space(), 1'b0);
        end
    endtask

    // quotes stay balanced; whitespace only inside quotes
    task automatic send_token(int unsigned len);
        bit          open;
        int unsigned r;
        logic [7:0]  b;
        open = 1'b0;
        for (int unsigned k = 0; k < len; k++) begin
            r = $urandom_range(0, 15);
            if (r == 0) begin
                b = dnh_pkg::CH_QUOTE;
                open = !open;
            end else if (r == 1 && open) begin
                b = pick_space();
            end else begin
                b = pick_plain();
            end
            send_byte(b, 1'b0);
        end
        if (open) begin
            send_byte(dnh_pkg::CH_QUOTE, 1'b0);
        end
    endtask

    task automatic send_noise(string kw, int unsigned n);
        int unsigned stop_at;
        int unsigned pos;
        int unsigned cnt;
        logic [7:0]  b;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            case ($urandom_range(0, 4))
                0: send_token($urandom_range(1, 7));
                1: begin
                    pos = $urandom_range(0, 3);
                    for (int unsigned k = 0; k < 4; k++) begin
                        if (k == pos) begin
                            do begin
                                b = pick_plain();
                            end while (b == kw[k]);
                            send_byte(b, 1'b0);
                        end else begin
                            send_byte(kw[k], 1'b0);
                        end
                    end
                end
                2: begin
                    cnt = $urandom_range(1, 3);
                    for (int unsigned k = 0; k < cnt; k++) begin
                        send_byte(kw[k], 1'b0);
                    end
                end
                3: send_text(pick_other(kw));
                default: begin
                    send_byte(dnh_pkg::CH_QUOTE, 1'b0);
                    send_byte(pick_plain(), 1'b0);
                    send_byte(pick_space(), 1'b0);
                    send_byte(pick_plain(), 1'b0);
                    send_byte(dnh_pkg::CH_QUOTE, 1'b0);
                end
            endcase
            send_spaces();
        end
    endtask

    task automatic send_keyword(string kw, bit allow_suffix);
        while (sb.token_len != 0 &&
               (sb.phase == SEEK_GAME || sb.phase == SEEK_NAME || sb.phase == SEEK_SHA1)) begin
            send_byte(dnh_pkg::CH_SPACE, 1'b0);
        end
        case ($urandom_range(0, allow_suffix ? 2 : 1))
            0: send_text(kw);
            1: begin
                for (int unsigned k = 0; k < 4; k++) begin
                    send_byte(pick_plain(), 1'b0);
                end
                send_text(kw);
            end
            default: begin
                send_text(kw);
                send_token($urandom_range(1, 3));
            end
        endcase
        send_spaces();
    endtask

    task automatic write_name_limit(logic [7:0] v);
        while (sb.pending_items.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(posedge i_clk);
        sb.set_name_limit(v);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    initial begin : result_sink
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_armed && !hold_done && out_ch.valid) begin
                out_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_item(out_ch.out_kind, out_ch.out_byte, out_ch.out_last);
        end
    end

    initial begin : stimulus
        logic [7:0]  final_limit;
        int unsigned eff_limit;
        int unsigned name_len;
        int unsigned hash_len;
        int unsigned end_mode;
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = 8'd0;
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = 8'd0;
        in_ch.end_of_input = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_name_limit(8'd1);

        send_byte(dnh_pkg::CH_SPACE, 1'b0);
        send_byte(dnh_pkg::CH_TAB, 1'b0);
        send_byte(dnh_pkg::CH_CR, 1'b0);
        send_byte(dnh_pkg::CH_LF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(dnh_pkg::CH_SPACE, 1'b0);
        send_text("gam");
        send_byte(dnh_pkg::CH_LF, 1'b0);
        send_byte(dnh_pkg::CH_QUOTE, 1'b0);
        send_text("g");
        send_byte(dnh_pkg::CH_SPACE, 1'b0);
        send_text("e");
        send_byte(dnh_pkg::CH_QUOTE, 1'b0);
        send_byte(dnh_pkg::CH_SPACE, 1'b0);
        send_text("sha1");
        send_byte(dnh_pkg::CH_TAB, 1'b0);
        stop_input();

        write_name_limit(8'd0);
        send_noise("game", 90);
        stop_input();
        write_name_limit(8'd255);
        send_noise("game", 90);
        stop_input();
        case ($urandom_range(0, 3))
            0:       final_limit = 8'd0;
            1:       final_limit = 8'd1;
            2:       final_limit = 8'd255;
            default: final_limit = 8'($urandom_range(2, 60));
        endcase
        write_name_limit(final_limit);

        send_keyword("game", 1'b1);
        send_noise("name", 40);
        send_keyword("name", 1'b1);
        eff_limit = (final_limit == 8'd0) ? 1 : int'(final_limit);
        name_len = (sb.phase == GRAB_NAME) ? $urandom_range(1, eff_limit + 3)
                                           : $urandom_range(1, 8);
        send_token(name_len);
        send_spaces();
        send_noise("sha1", 40);
        send_keyword("sha1", 1'b0);

        end_mode = $urandom_range(0, 2);
        case (end_mode)
            0:       hash_len = $urandom_range(12, 253);
            1:       hash_len = $urandom_range(254, 262);
            default: hash_len = $urandom_range(12, 200);
        endcase
        hold_armed = 1'b1;
        send_token(hash_len / 2);
        calm = 1'b1;
        send_token(hash_len - hash_len / 2);
        if (end_mode == 2) begin
            send_byte(pick_plain(), 1'b1);
        end else begin
            send_spaces();
        end
        for (int unsigned k = 0; k < 4; k++) begin
            send_byte(8'($urandom_range(0, 255)), k[0]);
        end
        stop_input();

        while (sb.pending_items.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_dat_name_hash_extractor passed");
        end else begin
            $display("tb_dat_name_hash_extractor failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_dat_name_hash_extractor failed");
        $finish;
    end

endmodule
